/* src/oli_pkg.sv */
`timescale 1ns / 1ps
// Package for the ordered list block: sizes, operation and status codes,
// and the controller state type. Depends on nothing.
package oli_pkg;

	// Number of node slots in the node memory.
	localparam int CAPACITY = 64;
	// Bits of a slot address.
	localparam int IDX_W = $clog2(CAPACITY);
	// Bits of a link; the null link is the value CAPACITY.
	localparam int LINK_W = $clog2(CAPACITY + 1);
	// Bits of the node count, which runs from zero to CAPACITY.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// Bits of a stored value.
	localparam int VAL_W = 32;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

	typedef enum logic [1:0] {
		OP_APPEND    = 2'd0,
		OP_REM_HEAD  = 2'd1,
		OP_REM_TAIL  = 2'd2,
		OP_REM_MATCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_APP_WRITE,
		S_APP_LINK,
		S_UNLINK,
		S_FREE,
		S_DONE
	} state_t;

endpackage

/* src/oli_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the ordered list block: valid, ready, op and value.
// Depends on oli_pkg.
interface oli_req_if;
	import oli_pkg::*;

	logic                    valid;
	logic                    ready;
	op_t                     op;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

/* src/oli_rsp_if.sv */
`timescale 1ns / 1ps
// Response channel of the ordered list block: valid, ready, status,
// removed value and new length. Depends on oli_pkg.
interface oli_rsp_if;
	import oli_pkg::*;

	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic signed [VAL_W-1:0] removed_value;
	logic [CNT_W-1:0]        length;

	modport source (output valid, output status, output removed_value, output length,
		input ready);
	modport sink (input valid, input status, input removed_value, input length,
		output ready);
endinterface

/* src/ordered_list_insert_remove_top.sv */
`timescale 1ns / 1ps
// Ordered list of signed 32-bit values kept as a doubly linked list in three
// node memories (value, next link, prev link). One transaction on req gives
// exactly one transaction on rsp. The block handles one request at a time:
// append writes a node and links it (reading the free list first once slots
// are reused), remove head or tail fetches, unlinks and frees a node, and
// remove by value searches from the head, reading one node per cycle from
// the node memory. A refused request (full or empty) does no memory work.
// The result moves into the output register, which holds it until taken
// while the next request is accepted. No clearing pass is needed after reset.
// Depends on oli_pkg, oli_req_if, oli_rsp_if and oli_ram.
module ordered_list_insert_remove_top (
	input logic clk,
	input logic arst_n,
	oli_req_if.sink   req,
	oli_rsp_if.source rsp
);
	import oli_pkg::*;

	state_t state_q, state_d;

	// Request and list registers.
	op_t                     op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [LINK_W-1:0]       head_q, tail_q, free_head_q, bump_q;
	logic [CNT_W-1:0]        count_q;
	logic [LINK_W-1:0]       cur_q, slot_q, prev_q, next_q;
	status_t                 status_q;
	logic signed [VAL_W-1:0] removed_q;

	// Output register.
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [VAL_W-1:0] out_removed_q;
	logic [CNT_W-1:0]        out_length_q;

	// Memory ports.
	logic [IDX_W-1:0]  rd_addr;
	logic [VAL_W-1:0]  val_rd;
	logic [LINK_W-1:0] next_rd, prev_rd;
	logic              val_we, next_we, prev_we;
	logic [IDX_W-1:0]  val_wa, next_wa, prev_wa;
	logic [LINK_W-1:0] next_wd, prev_wd;

	logic accept, out_free, full, match;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign match    = (val_rd == val_q);

	oli_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
		.clk(clk), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_q),
		.rd_addr(rd_addr), .rd_data(val_rd)
	);

	oli_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
		.clk(clk), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
		.rd_addr(rd_addr), .rd_data(next_rd)
	);

	oli_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
		.clk(clk), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
		.rd_addr(rd_addr), .rd_data(prev_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_APPEND) begin
						if (full) begin
							state_d = S_DONE;
						end else if (bump_q != NULL_LINK) begin
							state_d = S_APP_WRITE;
						end else begin
							state_d = S_FETCH;
						end
					end else if (count_q == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				if (op_q == OP_APPEND) begin
					state_d = S_APP_WRITE;
				end else if (op_q != OP_REM_MATCH || match) begin
					state_d = S_UNLINK;
				end else if (next_rd == NULL_LINK) begin
					state_d = S_DONE;
				end
			end
			S_APP_WRITE: state_d = S_APP_LINK;
			S_APP_LINK:  state_d = S_DONE;
			S_UNLINK:    state_d = S_FREE;
			S_FREE:      state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory control and request ready.
	always_comb begin
		req.ready = 1'b0;
		rd_addr   = cur_q[IDX_W-1:0];
		val_we    = 1'b0;
		val_wa    = slot_q[IDX_W-1:0];
		next_we   = 1'b0;
		next_wa   = slot_q[IDX_W-1:0];
		next_wd   = NULL_LINK;
		prev_we   = 1'b0;
		prev_wa   = slot_q[IDX_W-1:0];
		prev_wd   = tail_q;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.op == OP_APPEND) begin
					rd_addr = free_head_q[IDX_W-1:0];
				end else if (req.op == OP_REM_TAIL) begin
					rd_addr = tail_q[IDX_W-1:0];
				end else begin
					rd_addr = head_q[IDX_W-1:0];
				end
			end
			S_FETCH: begin
				// The search reads the successor while checking this node.
				rd_addr = next_rd[IDX_W-1:0];
			end
			S_APP_WRITE: begin
				val_we  = 1'b1;
				next_we = 1'b1;
				prev_we = 1'b1;
			end
			S_APP_LINK: begin
				next_we = (tail_q != NULL_LINK);
				next_wa = tail_q[IDX_W-1:0];
				next_wd = slot_q;
			end
			S_UNLINK: begin
				next_we = (prev_q != NULL_LINK);
				next_wa = prev_q[IDX_W-1:0];
				next_wd = next_q;
				prev_we = (next_q != NULL_LINK);
				prev_wa = next_q[IDX_W-1:0];
				prev_wd = prev_q;
			end
			S_FREE: begin
				// The freed slot goes onto the free list through its next link.
				next_we = 1'b1;
				next_wa = cur_q[IDX_W-1:0];
				next_wd = free_head_q;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Controller and list registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NULL_LINK;
			tail_q      <= NULL_LINK;
			free_head_q <= NULL_LINK;
			bump_q      <= '0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept && req.op == OP_APPEND && !full) begin
						if (bump_q != NULL_LINK) begin
							bump_q <= bump_q + LINK_W'(1);
						end
					end
				end
				S_FETCH: begin
					if (op_q == OP_APPEND) begin
						free_head_q <= next_rd;
					end
				end
				S_APP_LINK: begin
					if (tail_q == NULL_LINK) begin
						head_q <= slot_q;
					end
					tail_q  <= slot_q;
					count_q <= count_q + CNT_W'(1);
				end
				S_UNLINK: begin
					if (prev_q == NULL_LINK) begin
						head_q <= next_q;
					end
					if (next_q == NULL_LINK) begin
						tail_q <= prev_q;
					end
				end
				S_FREE: begin
					free_head_q <= cur_q;
					count_q     <= count_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Per-request working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q      <= req.op;
					val_q     <= req.value;
					removed_q <= '0;
					slot_q    <= (bump_q != NULL_LINK) ? bump_q : free_head_q;
					cur_q     <= (req.op == OP_REM_TAIL) ? tail_q : head_q;
					if (req.op == OP_APPEND) begin
						status_q <= full ? ST_FULL : ST_OK;
					end else begin
						status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
					end
				end
			end
			S_FETCH: begin
				if (op_q != OP_APPEND) begin
					removed_q <= $signed(val_rd);
					prev_q    <= prev_rd;
					next_q    <= next_rd;
					if (op_q == OP_REM_MATCH && !match) begin
						cur_q <= next_rd;
						if (next_rd == NULL_LINK) begin
							status_q  <= ST_NOT_FOUND;
							removed_q <= '0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_length_q  <= count_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.removed_value = out_removed_q;
	assign rsp.length        = out_length_q;

	// The count never passes the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("node count above capacity");

	// Between requests, an empty list has no head and no tail, and a
	// nonempty one has both.
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> ((count_q == '0) == (head_q == NULL_LINK)))
		else $error("head link disagrees with node count");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> ((head_q == NULL_LINK) == (tail_q == NULL_LINK)))
		else $error("head and tail links disagree");

	// Fresh slots run out before the free list is used for an append.
	a_free_source: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH && op_q == OP_APPEND |-> bump_q == NULL_LINK)
		else $error("free list used while fresh slots remain");

	// A response appears only when a request finishes.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response without a finished request");
endmodule

/* src/oli_ram.sv */
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module oli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_insert_remove_top: a clocked driver, a
// clocked monitor and a queue-based list predictor with random idling on both sides.
// Depends on oli_pkg, oli_req_if, oli_rsp_if and the block itself.
module testbench;
	import oli_pkg::*;

	typedef struct {
		op_t                     op;
		logic signed [VAL_W-1:0] value;
	} list_cmd_t;

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] removed;
		logic [CNT_W-1:0]        length;
	} list_rsp_t;

	// A stall-free stretch sits between these transaction counts on each side.
	localparam int QUIET_LO = 400;
	localparam int QUIET_HI = 600;
	// Cycles without any transaction before the run is declared hung.
	localparam int HANG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1080;

	logic clk;
	logic arst_n;

	oli_req_if req_ch ();
	oli_rsp_if rsp_ch ();

	ordered_list_insert_remove_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_cmd_t               pending_cmds[$];
	list_rsp_t               expected_rsps[$];
	logic signed [VAL_W-1:0] list_contents[$];
	logic signed [VAL_W-1:0] recent_values[16];
	list_cmd_t               drive_cmd;
	list_rsp_t               head_rsp;
	int                      cmds_sent = 0;
	int                      rsps_seen = 0;
	int                      fail_count = 0;
	int                      hang_count;

	// The clock runs with a 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Applies one command to the modeled list and returns the result it must give.
	function automatic list_rsp_t apply_list_cmd(op_t op, logic signed [VAL_W-1:0] v);
		list_rsp_t r;
		int        hit;
		r.status = ST_OK;
		r.removed = '0;
		hit = -1;
		if (op == OP_APPEND) begin
			if (list_contents.size() >= CAPACITY)
				r.status = ST_FULL;
			else
				list_contents.push_back(v);
		end else if (list_contents.size() == 0) begin
			r.status = ST_EMPTY;
		end else if (op == OP_REM_HEAD) begin
			r.removed = list_contents.pop_front();
		end else if (op == OP_REM_TAIL) begin
			r.removed = list_contents.pop_back();
		end else begin
			// Search from the head for the first node holding the value.
			for (int i = 0; i < list_contents.size(); i++)
				if (hit < 0 && list_contents[i] == v)
					hit = i;
			if (hit < 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				r.removed = list_contents[hit];
				list_contents.delete(hit);
			end
		end
		r.length = CNT_W'(list_contents.size());
		return r;
	endfunction

	task automatic queue_cmd(op_t op, logic signed [VAL_W-1:0] v);
		list_cmd_t c;
		c.op = op;
		c.value = v;
		pending_cmds.push_back(c);
	endtask

	// Picks a value, often one appended lately so that searches find it.
	function automatic logic signed [VAL_W-1:0] pick_value(bit want_match);
		int sel;
		sel = $urandom_range(99);
		if (want_match && sel < 60)
			return recent_values[$urandom_range(15)];
		if (sel < 80)
			return VAL_W'($signed($urandom_range(4)) - 2);
		return $urandom;
	endfunction

	// Builds the random part out of bursts that fill, drain or churn the list.
	task automatic build_random_cmds();
		int                      burst_len;
		int                      mode;
		int                      append_pct;
		int                      slot;
		logic signed [VAL_W-1:0] v;
		op_t                     op;
		slot = 0;
		mode = 0;
		for (int i = 0; i < 16; i++)
			recent_values[i] = $urandom;
		while (pending_cmds.size() < RANDOM_ITEMS + 22) begin
			burst_len = (mode == 0) ? $urandom_range(66, 80) : $urandom_range(20, 80);
			append_pct = (mode == 0) ? 96 : (mode == 1) ? 10 : 50;
			for (int n = 0; n < burst_len; n++) begin
				if ($urandom_range(99) < append_pct) begin
					op = OP_APPEND;
					v = pick_value(1'b0);
					recent_values[slot] = v;
					slot = (slot + 1) % 16;
				end else begin
					case ($urandom_range(2))
						0: op = OP_REM_HEAD;
						1: op = OP_REM_TAIL;
						default: op = OP_REM_MATCH;
					endcase
					v = (op == OP_REM_MATCH) ? pick_value(1'b1) : $urandom;
				end
				queue_cmd(op, v);
			end
			mode = $urandom_range(2);
		end
	endtask

	// Stimulus, reset and the end of the run.
	initial begin
		arst_n = 1'b0;

		// Every remove on an empty list.
		queue_cmd(OP_REM_HEAD, 32'sh0);
		queue_cmd(OP_REM_TAIL, -32'sd1);
		queue_cmd(OP_REM_MATCH, 32'sh0);
		// Extreme values, with a duplicate of the most negative one.
		queue_cmd(OP_APPEND, 32'sh8000_0000);
		queue_cmd(OP_APPEND, 32'sh7FFF_FFFF);
		queue_cmd(OP_APPEND, 32'sh0);
		queue_cmd(OP_APPEND, -32'sd1);
		queue_cmd(OP_APPEND, 32'sh8000_0000);
		// Values that are absent, one of them a single bit away from a stored one.
		queue_cmd(OP_REM_MATCH, 32'sd5);
		queue_cmd(OP_REM_MATCH, 32'sh7FFF_FFFE);
		// Removal by value of a middle node, of the head with a later duplicate,
		// and of the tail.
		queue_cmd(OP_REM_MATCH, -32'sd1);
		queue_cmd(OP_REM_MATCH, 32'sh8000_0000);
		queue_cmd(OP_REM_MATCH, 32'sh0);
		queue_cmd(OP_REM_MATCH, 32'sh8000_0000);
		queue_cmd(OP_REM_TAIL, 32'sh0);
		queue_cmd(OP_REM_TAIL, 32'sh0);
		queue_cmd(OP_REM_HEAD, 32'sh0);
		// A single node removed by value, then a remove on the empty list again.
		queue_cmd(OP_APPEND, 32'sh5555_5555);
		queue_cmd(OP_APPEND, 32'shAAAA_AAAA);
		queue_cmd(OP_REM_HEAD, 32'sh0);
		queue_cmd(OP_REM_MATCH, 32'shAAAA_AAAA);
		queue_cmd(OP_REM_MATCH, 32'shAAAA_AAAA);
		build_random_cmds();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every command is taken and every result is back.
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
		repeat (80) @(negedge clk);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Driver: predicts each accepted transaction and offers the next command.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= OP_APPEND;
			req_ch.value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsps.push_back(apply_list_cmd(req_ch.op, req_ch.value));
				cmds_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_cmds.size() != 0 &&
					((cmds_sent >= QUIET_LO && cmds_sent < QUIET_HI) ||
					$urandom_range(99) >= 10)) begin
					drive_cmd = pending_cmds.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.op <= drive_cmd.op;
					req_ch.value <= drive_cmd.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsps_seen++;
				if (expected_rsps.size() == 0) begin
					$error("result transaction with no command outstanding");
					fail_count++;
				end else begin
					head_rsp = expected_rsps.pop_front();
					if (rsp_ch.status !== head_rsp.status) begin
						$error("status: expected %0d, got %0d", head_rsp.status,
							rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.removed_value !== head_rsp.removed) begin
						$error("removed_value: expected %0d, got %0d", head_rsp.removed,
							rsp_ch.removed_value);
						fail_count++;
					end
					if (rsp_ch.length !== head_rsp.length) begin
						$error("length: expected %0d, got %0d", head_rsp.length,
							rsp_ch.length);
						fail_count++;
					end
				end
			end
			rsp_ch.ready <= (rsps_seen >= QUIET_LO && rsps_seen < QUIET_HI) ||
				($urandom_range(99) >= 10);
		end
	end

	// Watchdog: ends the run when no transaction happens for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			hang_count <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			hang_count <= 0;
		end else if (hang_count >= HANG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			hang_count <= hang_count + 1;
		end
	end

endmodule
